[sv/drle_pkg.sv]
// drle_pkg: shared constants, state encoding and the decimal multiple table
// for the decimal digit run-length encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package drle_pkg;

  localparam int MAX_DIGITS = 9;
  localparam int COUNT_BITS = 16;

  localparam int VALUE_W = 30;
  localparam int DIGIT_W = 4;
  localparam int RUN_W   = 16;
  localparam int NPOS    = 10;
  localparam int POS_W   = 4;
  localparam int CMP_W   = 34;
  localparam int KEEP_TOP = (MAX_DIGITS < NPOS) ? MAX_DIGITS : NPOS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_FLUSH
  } drle_state_t;

  typedef logic [NPOS-1:0][9:0][CMP_W-1:0] mult_tab_t;

  function automatic mult_tab_t build_mult_tab();
    mult_tab_t tab;
    longint unsigned p10;
    p10 = 1;
    for (int p = 0; p < NPOS; p++) begin
      for (int k = 0; k < 10; k++) begin
        tab[p][k] = CMP_W'(p10 * longint'(k));
      end
      p10 = p10 * 10;
    end
    return tab;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

`default_nettype wire

[sv/drle_digit_step.sv]
// drle_digit_step: extracts the decimal digit at one position of the running
// remainder and returns the remainder with that digit removed; uses drle_pkg
`timescale 1ns / 1ps
`default_nettype none

module drle_digit_step
  import drle_pkg::*;
(
  input  wire logic [VALUE_W-1:0] rem_in,
  input  wire logic [POS_W-1:0]   pos,
  output logic      [DIGIT_W-1:0] digit,
  output logic      [VALUE_W-1:0] rem_out
);

  logic [CMP_W-1:0] rem_ext;
  logic [9:1]       ge;
  logic [CMP_W-1:0] sub_val;

  assign rem_ext = CMP_W'(rem_in);

  always_comb begin
    for (int k = 1; k < 10; k++) begin
      ge[k] = rem_ext >= MULT_TAB[pos][k];
    end
  end

  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (ge[k]) begin
        digit = DIGIT_W'(k);
      end
    end
  end

  assign sub_val = rem_ext - MULT_TAB[pos][digit];
  assign rem_out = sub_val[VALUE_W-1:0];

endmodule

`default_nettype wire

[sv/decimal_digit_run_length_encoder_unit.sv]
// Decimal digit run-length encoder. A transaction on the input carries one
// value; its decimal digits (most significant first, leading zeros dropped,
// only the low MAX_DIGITS digits kept, zero giving one digit 0) join a single
// digit stream that is run-length encoded across values. Each finished run
// leaves as a (digit, count) transaction; the input marked last flushes the
// open run with last_out set and clears the run state. An input is accepted
// in ST_IDLE, then the shared compare-subtract digit unit handles one decimal
// position of the 30-bit value (10 positions) per ST_DIGIT step; a last input
// then passes through ST_FLUSH. in_ready stays low until the unit is back in
// ST_IDLE. A digit step or the flush waits while a pair must leave and the
// output register is still held. A result register sits in front of the
// output, so a waiting result does not block the next input.
// Depends on drle_pkg and drle_digit_step.
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_run_length_encoder_unit
  import drle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               in_last_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [DIGIT_W-1:0] out_digit,
  output logic      [RUN_W-1:0]   out_run_count,
  output logic                    out_last_out
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  drle_state_t state_r, state_nxt;

  logic [VALUE_W-1:0]    rem_r, rem_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  last_r, last_nxt;
  logic                  started_r, started_nxt;
  logic [DIGIT_W-1:0]    pend_digit_r, pend_digit_nxt;
  logic [COUNT_BITS-1:0] pend_count_r, pend_count_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]    out_digit_r, out_digit_nxt;
  logic [RUN_W-1:0]      out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [DIGIT_W-1:0] step_digit;
  logic [VALUE_W-1:0] step_rem;
  logic               emit_ok;
  logic               skip;
  logic               advance;

  drle_digit_step u_step (
    .rem_in  (rem_r),
    .pos     (pos_r),
    .digit   (step_digit),
    .rem_out (step_rem)
  );

  assign emit_ok = !out_valid_r || out_ready;
  assign skip    = (pos_r >= POS_W'(KEEP_TOP)) ||
                   (!started_r && (step_digit == '0) && (pos_r != '0));

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    started_nxt    = started_r;
    pend_digit_nxt = pend_digit_r;
    pend_count_nxt = pend_count_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_digit_nxt  = out_digit_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    advance        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rem_nxt     = in_value;
          last_nxt    = in_last_in;
          pos_nxt     = POS_W'(NPOS - 1);
          started_nxt = 1'b0;
          state_nxt   = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        advance = 1'b1;
        if (!skip) begin
          if (!pend_valid_r) begin
            started_nxt    = 1'b1;
            pend_valid_nxt = 1'b1;
            pend_digit_nxt = step_digit;
            pend_count_nxt = COUNT_BITS'(1);
          end else if (step_digit == pend_digit_r) begin
            started_nxt = 1'b1;
            if (pend_count_r != CNT_MAX) begin
              pend_count_nxt = pend_count_r + COUNT_BITS'(1);
            end
          end else if (emit_ok) begin
            started_nxt    = 1'b1;
            out_valid_nxt  = 1'b1;
            out_digit_nxt  = pend_digit_r;
            out_count_nxt  = RUN_W'(pend_count_r);
            out_last_nxt   = 1'b0;
            pend_digit_nxt = step_digit;
            pend_count_nxt = COUNT_BITS'(1);
          end else begin
            advance = 1'b0;
          end
        end
        if (advance) begin
          rem_nxt = step_rem;
          if (pos_r == '0) begin
            state_nxt = last_r ? ST_FLUSH : ST_IDLE;
          end else begin
            pos_nxt = pos_r - POS_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_digit_nxt  = pend_digit_r;
          out_count_nxt  = RUN_W'(pend_count_r);
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          pend_digit_nxt = '0;
          pend_count_nxt = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      started_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_digit_r <= '0;
      pend_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      started_r    <= started_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_digit_r <= pend_digit_nxt;
      pend_count_r <= pend_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    out_digit_r <= out_digit_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_digit     = out_digit_r;
  assign out_run_count = out_count_r;
  assign out_last_out  = out_last_r;

endmodule

`default_nettype wire

[sv/drle_checker.sv]
// drle_checker: port-level assertions for the decimal digit run-length
// encoder, bound to decimal_digit_run_length_encoder_unit; uses drle_pkg
`timescale 1ns / 1ps
`default_nettype none

module drle_checker
  import drle_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [DIGIT_W-1:0] out_digit,
  input wire logic [RUN_W-1:0]   out_run_count,
  input wire logic               out_last_out
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit) &&
      $stable(out_run_count) && $stable(out_last_out))
    else $error("output transaction changed while stalled");

  // one value in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit <= DIGIT_W'(9))
    else $error("digit out of range");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_count != '0 || COUNT_BITS > RUN_W)
    else $error("empty run emitted");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not quiet after reset");

endmodule

bind decimal_digit_run_length_encoder_unit drle_checker u_drle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_digit     (out_digit),
  .out_run_count (out_run_count),
  .out_last_out  (out_last_out)
);

`default_nettype wire
